// ----- hw/rtl/lpg_pkg.sv -----
// Package for the line pixel generator: beat types of both channels and
// fixed field widths and function codes. No dependencies.
`default_nettype none

package lpg_pkg;

    localparam int FIELD_W = 8;
    localparam int COLOR_W = 16;

    // Function codes of an input beat.
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] x_start;
        logic [FIELD_W-1:0] y_start;
        logic [FIELD_W-1:0] x_end;
        logic [FIELD_W-1:0] y_end;
        logic [COLOR_W-1:0] pen_color;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0] pix_x;
        logic [FIELD_W-1:0] pix_y;
        logic [COLOR_W-1:0] pix_color;
        logic               last_pixel;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- hw/rtl/lpg_front.sv -----
// Front end of the line pixel generator: takes input beats, works out the
// line setup for start commands and pushes commands into the queue. Uses lpg_pkg.
`default_nettype none

module lpg_front import lpg_pkg::*; #(
    parameter int COORD_BITS = 8
) (
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire t_in_beat                  i_in_beat,
    input  wire logic                      i_q_full,
    output logic                           o_q_push,
    output logic [5*COORD_BITS+COLOR_W+7:0] o_q_data
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic               func;
        logic [C-1:0]       x0;
        logic [C-1:0]       y0;
        logic               x_neg;
        logic               y_neg;
        logic               x_major;
        logic [C-1:0]       major_len;
        logic [C:0]         minor_twice;
        logic signed [C+2:0] decision;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    logic [C-1:0] x0, y0, x1, y1;
    logic [C-1:0] dx, dy, minor_len;
    logic         x_neg, y_neg, x_major;
    t_cmd         cmd;

    // Coordinates live at COORD_BITS inside the block.
    assign x0 = C'(i_in_beat.x_start);
    assign y0 = C'(i_in_beat.y_start);
    assign x1 = C'(i_in_beat.x_end);
    assign y1 = C'(i_in_beat.y_end);

    always_comb begin
        x_neg     = x1 < x0;
        y_neg     = y1 < y0;
        dx        = x_neg ? (x0 - x1) : (x1 - x0);
        dy        = y_neg ? (y0 - y1) : (y1 - y0);
        x_major   = dx > dy;
        minor_len = x_major ? dy : dx;

        cmd.func        = i_in_beat.func;
        cmd.x0          = x0;
        cmd.y0          = y0;
        cmd.x_neg       = x_neg;
        cmd.y_neg       = y_neg;
        cmd.x_major     = x_major;
        cmd.major_len   = x_major ? dx : dy;
        cmd.minor_twice = {minor_len, 1'b0};
        cmd.decision    = signed'({2'b00, minor_len, 1'b0})
                          - signed'({3'b000, cmd.major_len});
        cmd.color       = i_in_beat.pen_color;
    end

    // The queue's full flag comes from its registered count; reset also stalls.
    assign o_in_stall = i_q_full || !i_rst_n;
    assign o_q_push   = i_in_valid && !o_in_stall;
    assign o_q_data   = cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_fifo.sv -----
// Two-entry command queue between the front and back of the line pixel
// generator. No package dependencies.
`default_nettype none

module lpg_fifo #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_back.sv -----
// Back end of the line pixel generator: holds the Bresenham stepping state,
// runs one command per unstalled cycle, drives the output reg. Uses lpg_pkg.
`default_nettype none

module lpg_back import lpg_pkg::*; #(
    parameter int COORD_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire logic [5*COORD_BITS+COLOR_W+7:0] i_q_data,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output t_out_beat                       o_out_beat
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic               func;
        logic [C-1:0]       x0;
        logic [C-1:0]       y0;
        logic               x_neg;
        logic               y_neg;
        logic               x_major;
        logic [C-1:0]       major_len;
        logic [C:0]         minor_twice;
        logic signed [C+2:0] decision;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    function automatic logic [C-1:0] step_coord(input logic [C-1:0] v, input logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    t_cmd                cmd;
    logic                r_busy;
    logic [C-1:0]        r_cur_x, r_cur_y;
    logic signed [C+2:0] r_decision;
    logic [C:0]          r_minor_twice;
    logic [C-1:0]        r_major_len;
    logic [C-1:0]        r_steps;
    logic                r_x_neg, r_y_neg, r_x_major;
    logic [COLOR_W-1:0]  r_color;
    logic                r_out_valid;
    t_out_beat           r_out_beat;

    logic                is_start, emit, last;
    logic [C-1:0]        s_x, s_y, s_major_len, s_steps;
    logic signed [C+2:0] s_dec, d_mid, d_next;
    logic [C:0]          s_minor_twice;
    logic                s_x_neg, s_y_neg, s_x_major;
    logic [COLOR_W-1:0]  s_color;
    logic [C-1:0]        a_x, a_y;

    assign cmd      = i_q_data;
    assign o_q_pop  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign is_start = cmd.func == FUNC_START;
    assign emit     = o_q_pop && (is_start || r_busy);

    // A start takes its setup from the command, an advance from the state.
    always_comb begin
        s_x           = is_start ? cmd.x0 : r_cur_x;
        s_y           = is_start ? cmd.y0 : r_cur_y;
        s_dec         = is_start ? cmd.decision : r_decision;
        s_minor_twice = is_start ? cmd.minor_twice : r_minor_twice;
        s_major_len   = is_start ? cmd.major_len : r_major_len;
        s_steps       = is_start ? '0 : r_steps;
        s_x_neg       = is_start ? cmd.x_neg : r_x_neg;
        s_y_neg       = is_start ? cmd.y_neg : r_y_neg;
        s_x_major     = is_start ? cmd.x_major : r_x_major;
        s_color       = is_start ? cmd.color : r_color;
        last          = s_steps >= s_major_len;

        // One Bresenham step: minor axis on a non-negative decision term,
        // then always the major axis.
        a_x   = s_x;
        a_y   = s_y;
        d_mid = s_dec;
        if (!s_dec[C+2]) begin
            d_mid = s_dec - signed'({2'b00, s_major_len, 1'b0});
            if (s_x_major) begin
                a_y = step_coord(s_y, s_y_neg);
            end else begin
                a_x = step_coord(s_x, s_x_neg);
            end
        end
        d_next = d_mid + signed'({2'b00, s_minor_twice});
        if (s_x_major) begin
            a_x = step_coord(s_x, s_x_neg);
        end else begin
            a_y = step_coord(s_y, s_y_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy <= !last;
            end
            priority if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_minor_twice <= s_minor_twice;
            r_major_len   <= s_major_len;
            r_x_neg       <= s_x_neg;
            r_y_neg       <= s_y_neg;
            r_x_major     <= s_x_major;
            r_color       <= s_color;
            r_out_beat.pix_x      <= FIELD_W'(s_x);
            r_out_beat.pix_y      <= FIELD_W'(s_y);
            r_out_beat.pix_color  <= s_color;
            r_out_beat.last_pixel <= last;
            if (last) begin
                r_cur_x    <= s_x;
                r_cur_y    <= s_y;
                r_decision <= s_dec;
                r_steps    <= s_steps;
            end else begin
                r_cur_x    <= a_x;
                r_cur_y    <= a_y;
                r_decision <= d_next;
                r_steps    <= s_steps + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

// ----- hw/rtl/line_pixel_generator_top.sv -----
// Top level of the line pixel generator: front end, command queue and back
// end. Depends on lpg_pkg, lpg_front, lpg_fifo and lpg_back.
`default_nettype none

// A Bresenham line rasterizer with valid/stall channels on both sides. A
// start beat (func = FUNC_START) carries both endpoints and the pen color and
// yields the first pixel of the line at once; every advance beat (func =
// FUNC_ADVANCE) yields the next pixel, and the final pixel of a line has
// last_pixel set. An advance beat while no line is in progress is consumed
// and gives no output beat, and a start beat abandons any line in progress.
// The front end works out the deltas, step directions and major axis of a
// start beat and writes every command into a two-entry queue; the back end
// takes one command per cycle, steps the decision term and coordinates and
// loads the output register. The block sustains one input beat and one
// pixel per cycle when the output is not stalled. An accepted beat is
// written into the queue, and the back end pops it from there and loads
// its pixel into the output register, where the receiver can take it.
// While a pixel waits there on an output stall, it is held and the queue
// is not popped, and once the queue is full the input is stalled.
// Coordinates are carried internally at COORD_BITS bits: port
// coordinates are truncated or zero-extended to it.
module line_pixel_generator_top import lpg_pkg::*; #(
    parameter int COORD_BITS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    // One queued command: function, start point, directions, major axis,
    // major length, twice the minor delta, initial decision term and color.
    localparam int CMD_W = 5 * COORD_BITS + COLOR_W + 8;

    logic             q_push, q_full, q_pop, q_valid;
    logic [CMD_W-1:0] q_wdata, q_rdata;

    lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    lpg_fifo #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    lpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lpg_checker.sv -----
// Port checker for the line pixel generator and its bind to the top level.
// Depends on lpg_pkg and line_pixel_generator_top.
`default_nettype none

module lpg_checker import lpg_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_beat
);

    // A stalled output beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_beat))
        else $error("output payload changed while stalled");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the command queue, so input is taken right after it.
    a_rst_in: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 && i_rst_n |-> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind line_pixel_generator_top lpg_checker u_lpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire

// ----- test/line_pixel_generator_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_pixel_generator_top: random and directed lines,
// predicted pixel by pixel and compared on the output channel.
// Depends on lpg_pkg and the line_pixel_generator_top RTL only.

module line_pixel_generator_top_test;
    import lpg_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles without any accepted beat
    localparam int HOLD_CYCLES  = 80;    // long output hold-off in the last phase
    localparam int PHASE_PIXELS = 250;   // pixel-producing beats per random phase
    localparam int DRAIN_CYCLES = 20;    // idle cycles after the last phase, leave plenty

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    line_pixel_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Beats waiting to be offered, and pixels the rasterizer copy says must come out.
    t_in_beat  beats_pending[$];
    t_out_beat pixels_due[$];

    // Idle rates in percent; the stimulus process changes them between phases only.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_armed   = 1'b0;

    int pixels_checked = 0;
    int bad_beats      = 0;
    int stray_advances = 0;
    int lines_queued   = 0;
    int lines_cut      = 0;

    // ------------------------------------------------------------------
    // Rasterizer copy. It keeps its own line state and advances it for
    // every accepted input beat, pushing the pixel, if any, that beat must yield.
    // ------------------------------------------------------------------
    logic       line_active   = 1'b0;
    logic [7:0] px            = '0;
    logic [7:0] py            = '0;
    int         err_term      = 0;
    int         minor2        = 0;
    int         major2        = 0;
    int         major_span    = 0;
    int         steps_taken   = 0;
    logic       x_down        = 1'b0;
    logic       y_down        = 1'b0;
    logic       x_leads       = 1'b0;
    logic [15:0] latched_color = '0;

    // Move to the next pixel: the minor axis steps when the decision term is
    // not negative, the major axis steps every time.
    task automatic move_along();
        if (err_term >= 0) begin
            err_term -= major2;
            if (x_leads) begin
                py = y_down ? py - 8'd1 : py + 8'd1;
            end else begin
                px = x_down ? px - 8'd1 : px + 8'd1;
            end
        end
        err_term += minor2;
        if (x_leads) begin
            px = x_down ? px - 8'd1 : px + 8'd1;
        end else begin
            py = y_down ? py - 8'd1 : py + 8'd1;
        end
    endtask

    task automatic rasterize_beat(input t_in_beat b);
        int dx;
        int dy;
        logic fin;
        t_out_beat pix;
        if (b.func == FUNC_START) begin
            // A start always restarts, whatever line was running.
            x_down = b.x_end < b.x_start;
            y_down = b.y_end < b.y_start;
            dx = x_down ? int'(b.x_start) - int'(b.x_end) : int'(b.x_end) - int'(b.x_start);
            dy = y_down ? int'(b.y_start) - int'(b.y_end) : int'(b.y_end) - int'(b.y_start);
            // Equal deltas make y the major axis.
            x_leads = dx > dy;
            major_span = x_leads ? dx : dy;
            minor2 = 2 * (x_leads ? dy : dx);
            major2 = 2 * major_span;
            err_term = minor2 - major_span;
            px = b.x_start;
            py = b.y_start;
            latched_color = b.pen_color;
            fin = (major_span == 0);
            pix = '{pix_x: px, pix_y: py, pix_color: latched_color, last_pixel: fin};
            pixels_due.push_back(pix);
            if (fin) begin
                line_active = 1'b0;
            end else begin
                move_along();
                steps_taken = 1;
                line_active = 1'b1;
            end
        end else if (line_active) begin
            fin = (steps_taken >= major_span);
            pix = '{pix_x: px, pix_y: py, pix_color: latched_color, last_pixel: fin};
            pixels_due.push_back(pix);
            if (fin) begin
                // The position is not moved past the final pixel.
                line_active = 1'b0;
            end else begin
                move_along();
                steps_taken++;
            end
        end else begin
            // An advance with no line running is swallowed without output.
            stray_advances++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. A beat is taken at an edge where valid is high and stall
    // low; it is predicted right there. A stalled beat is held unchanged,
    // and a new one is offered only when the slot is free and the random
    // idle roll allows it. Valid and payload get one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_side
        logic taken;
        if (i_rst_n) begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                rasterize_beat(i_in_beat);
            end
            if (!i_in_valid || taken) begin
                if (beats_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_beat  <= beats_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side. Every accepted pixel beat is checked field by field
    // against the oldest prediction. Stall is drawn at random, except for
    // one long hold-off that this process counts down itself once armed.
    // ------------------------------------------------------------------
    int   hold_left  = 0;
    logic hold_spent = 1'b0;

    always @(posedge i_clk) begin : rx_side
        t_out_beat want;
        logic stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixels_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10) begin
                    $display("unexpected pixel beat: x=%0d y=%0d color=%h last=%0b",
                             o_out_beat.pix_x, o_out_beat.pix_y,
                             o_out_beat.pix_color, o_out_beat.last_pixel);
                end
            end else begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (o_out_beat.pix_x !== want.pix_x || o_out_beat.pix_y !== want.pix_y ||
                    o_out_beat.pix_color !== want.pix_color ||
                    o_out_beat.last_pixel !== want.last_pixel) begin
                    bad_beats++;
                    if (bad_beats <= 10) begin
                        $display("pixel %0d wrong: expected x=%0d y=%0d color=%h last=%0b",
                                 pixels_checked, want.pix_x, want.pix_y,
                                 want.pix_color, want.last_pixel);
                        $display("                  got x=%0d y=%0d color=%h last=%0b",
                                 o_out_beat.pix_x, o_out_beat.pix_y,
                                 o_out_beat.pix_color, o_out_beat.last_pixel);
                    end
                end
            end
        end
        if (!i_rst_n) begin
            stall_next = 1'b0;
        end else if (hold_left != 0) begin
            stall_next = 1'b1;
            hold_left--;
        end else if (hold_armed && !hold_spent) begin
            // The sender keeps offering beats meanwhile, so the block fills
            // up and must stall its input.
            stall_next = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            hold_spent = 1'b1;
        end else begin
            stall_next = $urandom_range(99, 0) < recv_stall_pct;
        end
        i_out_stall <= stall_next;
    end

    // Watchdog: a run that stops moving beats on either side is broken.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles, %0d pixels still due",
                     QUIET_LIMIT, pixels_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic queue_start(input logic [7:0] x0, input logic [7:0] y0,
                               input logic [7:0] x1, input logic [7:0] y1,
                               input logic [15:0] color);
        t_in_beat b;
        b.func      = FUNC_START;
        b.x_start   = x0;
        b.y_start   = y0;
        b.x_end     = x1;
        b.y_end     = y1;
        b.pen_color = color;
        beats_pending.push_back(b);
    endtask

    // Advance beats carry random junk in the fields that only a start reads.
    task automatic queue_advances(input int count);
        logic [63:0] noise;
        t_in_beat b;
        for (int n = 0; n < count; n++) begin
            noise = {$urandom, $urandom};
            b = noise[$bits(t_in_beat)-1:0];
            b.func = FUNC_ADVANCE;
            beats_pending.push_back(b);
        end
    endtask

    // One random line: mostly walked to its end, sometimes cut short by the
    // next start, sometimes followed by advances that land on an idle block.
    task automatic queue_line(input int reach, output int useful);
        logic [63:0] noise;
        t_in_beat b;
        int span;
        int adv;
        int roll;
        noise = {$urandom, $urandom};
        b = noise[$bits(t_in_beat)-1:0];
        b.func  = FUNC_START;
        b.x_end = 8'($urandom_range(b.x_start + reach > 255 ? 255 : b.x_start + reach,
                                    b.x_start < reach ? 0 : b.x_start - reach));
        b.y_end = 8'($urandom_range(b.y_start + reach > 255 ? 255 : b.y_start + reach,
                                    b.y_start < reach ? 0 : b.y_start - reach));
        span = (b.x_end > b.x_start) ? b.x_end - b.x_start : b.x_start - b.x_end;
        if (((b.y_end > b.y_start) ? b.y_end - b.y_start : b.y_start - b.y_end) > span) begin
            span = (b.y_end > b.y_start) ? b.y_end - b.y_start : b.y_start - b.y_end;
        end
        beats_pending.push_back(b);
        roll = $urandom_range(99, 0);
        if (roll < 12 && span > 0) begin
            adv = $urandom_range(span - 1, 0);
            lines_cut++;
        end else if (roll < 20) begin
            adv = span + $urandom_range(2, 1);
        end else begin
            adv = span;
        end
        queue_advances(adv);
        lines_queued++;
        useful = 1 + (adv < span ? adv : span);
    endtask

    // Most lines are short; a few span a large part of the panel or all of it.
    task automatic queue_random(input int pixels, input int wide_reach);
        int made;
        int got;
        int roll;
        made = 0;
        while (made < pixels) begin
            roll = $urandom_range(99, 0);
            queue_line(roll < 80 ? 10 : (roll < 96 ? wide_reach : 255), got);
            made += got;
        end
    endtask

    // Wait until every beat is taken and every predicted pixel has arrived.
    task automatic settle();
        @(negedge i_clk);
        while (beats_pending.size() != 0 || i_in_valid || pixels_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines, no idling. An advance straight after reset, a
        // single-point line at the far corner, a short shallow line walked
        // one step past its end, a steep line running up and left, and two
        // full-span lines each abandoned by the next start.
        queue_advances(1);
        queue_start(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        queue_advances(1);
        queue_start(8'd0, 8'd0, 8'd3, 8'd1, 16'h0000);
        queue_advances(4);
        queue_start(8'd200, 8'd255, 8'd198, 8'd250, 16'hF800);
        queue_advances(5);
        queue_start(8'd0, 8'd255, 8'd255, 8'd0, 16'h07E0);
        queue_advances(3);
        queue_start(8'd255, 8'd0, 8'd0, 8'd0, 16'h001F);
        queue_advances(2);
        settle();

        // Random phases: free running, sender gaps, receiver stalls, both.
        queue_random(PHASE_PIXELS, 60);
        settle();
        send_idle_pct = 61;
        queue_random(PHASE_PIXELS, 60);
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        queue_random(PHASE_PIXELS, 60);
        settle();
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        queue_random(PHASE_PIXELS, 60);
        settle();

        // Back-pressure phase: the sender never idles and the receiver
        // holds off for a long stretch right at the start.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(PHASE_PIXELS, 120);
        hold_armed = 1'b1;
        settle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Checked %0d pixels from %0d lines (%0d cut short), %0d advances on an idle block.",
                 pixels_checked, lines_queued, lines_cut, stray_advances);
        $display("Phases: free running, sender gaps, output stalls, both, and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (bad_beats == 0 && pixels_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d bad pixel beats, %0d pixels never arrived",
                     bad_beats, pixels_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
